/* hw/rtl/schl_pkg.sv */
// Shared types and constants for the state change history log.
// Used by the front, queue, back and top-level modules; no dependencies.
`default_nettype none
package schl_pkg;

	localparam int DEPTH     = 16;
	localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int READ_CNT  = (DEPTH < 16) ? DEPTH : 16;
	localparam int AGE_W     = 4;
	localparam int CODE_W    = 8;
	localparam int TIME_W    = 32;
	localparam int QUEUE_CNT = 2;

	localparam int S_DATA_W = 40;  // state_code, time_value
	localparam int M_DATA_W = 48;  // entry_state, entry_time, entry_age, pad

	typedef enum logic [1:0] {
		OP_NOTIFY = 2'd0,
		OP_TICK   = 2'd1,
		OP_SET    = 2'd2,
		OP_READ   = 2'd3
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [CODE_W-1:0] code;
		logic [TIME_W-1:0] tval;
	} cmd_t;

endpackage
`default_nettype wire

/* hw/rtl/schl_front.sv */
// Front end: takes input requests, decodes the mode and holds one command.
// Depends on schl_pkg.
`default_nettype none
module schl_front (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          s_tvalid,
	output logic                         s_tready,
	input  wire  [schl_pkg::S_DATA_W-1:0] s_tdata,  // state_code, time_value
	input  wire  [1:0]                   s_tuser,  // mode
	output logic                         push,
	input  wire                          push_ready,
	output schl_pkg::cmd_t               push_cmd
);
	import schl_pkg::*;

	logic hold_valid_q;
	cmd_t cmd_q;
	op_t  op_dec;

	// every 2-bit mode value is a defined operation
	assign op_dec = op_t'(s_tuser);

	assign push     = hold_valid_q;
	assign push_cmd = cmd_q;
	assign s_tready = !hold_valid_q || push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
		end else if (s_tready) begin
			hold_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_q.op   <= op_dec;
			cmd_q.code <= s_tdata[CODE_W-1:0];
			cmd_q.tval <= s_tdata[CODE_W +: TIME_W];
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/schl_queue.sv */
// Short command queue between front and back end.
// Depends on schl_pkg.
`default_nettype none
module schl_queue (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            push,
	output logic           push_ready,
	input  schl_pkg::cmd_t push_cmd,
	output logic           pop_valid,
	input  wire            pop,
	output schl_pkg::cmd_t pop_cmd
);
	import schl_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_CNT);

	cmd_t             mem_q [QUEUE_CNT];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   cnt_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (cnt_q != (PTR_W+1)'(QUEUE_CNT));
	assign pop_valid  = (cnt_q != '0);
	assign pop_cmd    = mem_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/schl_back.sv */
// Back end: runs commands against the history ring, timestamp and readout.
// Depends on schl_pkg.
`default_nettype none
module schl_back (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           cfg_we,
	input  wire  [schl_pkg::CODE_W-1:0]   cfg_wdata,
	input  wire                           pop_valid,
	output logic                          pop,
	input  schl_pkg::cmd_t                pop_cmd,
	output logic                          m_tvalid,
	input  wire                           m_tready,
	output logic [schl_pkg::M_DATA_W-1:0] m_tdata,
	output logic                          m_tlast
);
	import schl_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_READ
	} state_t;

	state_t            state_q;
	logic [CODE_W-1:0] off_q;
	logic [CODE_W-1:0] last_state_q;
	logic [IDX_W-1:0]  wr_idx_q;
	logic [TIME_W-1:0] time_q;
	logic [DEPTH-1:0]  valid_q;
	logic [IDX_W-1:0]  pos_q;
	logic [AGE_W-1:0]  age_q;

	logic [CODE_W-1:0] st_state_q [DEPTH];
	logic [TIME_W-1:0] st_time_q  [DEPTH];

	logic              notify_hit;
	logic              slot_free;
	logic              last_now;
	logic [IDX_W-1:0]  pos_dec;
	logic [IDX_W-1:0]  wr_idx_inc;
	logic [CODE_W-1:0] rd_state;
	logic [TIME_W-1:0] rd_time;

	assign pop        = (state_q == ST_IDLE) && pop_valid;
	assign notify_hit = pop && (pop_cmd.op == OP_NOTIFY) && (pop_cmd.code != last_state_q);
	assign slot_free  = !m_tvalid || m_tready;
	assign last_now   = (age_q == AGE_W'(READ_CNT - 1));
	assign pos_dec    = (pos_q == '0) ? IDX_W'(DEPTH - 1) : pos_q - 1'b1;
	assign wr_idx_inc = (wr_idx_q == IDX_W'(DEPTH - 1)) ? '0 : wr_idx_q + 1'b1;
	// entries never written since the last clear read as the off code
	assign rd_state   = valid_q[pos_dec] ? st_state_q[pos_dec] : off_q;
	assign rd_time    = valid_q[pos_dec] ? st_time_q[pos_dec] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			off_q        <= '0;
			last_state_q <= '0;
			wr_idx_q     <= '0;
			time_q       <= '0;
			valid_q      <= '0;
			pos_q        <= '0;
			age_q        <= '0;
			m_tvalid     <= 1'b0;
			m_tdata      <= '0;
			m_tlast      <= 1'b0;
		end else begin
			// during a readout the read branch reloads the output register
			if (m_tvalid && m_tready && (state_q != ST_READ)) begin
				m_tvalid <= 1'b0;
			end
			if (cfg_we) begin
				// reload off code and clear the ring; the timestamp stays
				off_q        <= cfg_wdata;
				last_state_q <= cfg_wdata;
				wr_idx_q     <= '0;
				valid_q      <= '0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						case (pop_cmd.op)
							OP_NOTIFY: begin
								if (notify_hit) begin
									last_state_q      <= pop_cmd.code;
									valid_q[wr_idx_q] <= 1'b1;
									wr_idx_q          <= wr_idx_inc;
								end
							end
							OP_TICK: time_q <= time_q + 1'b1;
							OP_SET:  time_q <= pop_cmd.tval;
							default: begin
								pos_q   <= wr_idx_q;
								age_q   <= '0;
								state_q <= ST_READ;
							end
						endcase
					end
				end
				ST_READ: begin
					if (slot_free) begin
						m_tvalid <= 1'b1;
						m_tdata  <= {{(M_DATA_W - CODE_W - TIME_W - AGE_W){1'b0}},
							age_q, rd_time, rd_state};
						m_tlast  <= last_now;
						pos_q    <= pos_dec;
						age_q    <= age_q + 1'b1;
						if (last_now) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (notify_hit) begin
			st_state_q[wr_idx_q] <= pop_cmd.code;
			st_time_q[wr_idx_q]  <= time_q;
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/state_change_history_log_unit.sv */
// State change history log: a ring of timestamped state codes.
// Built from schl_front, schl_queue and schl_back; uses schl_pkg.
//
// Input stream s_*: s_tuser carries the mode (notify, tick, set timestamp,
// read history); s_tdata carries the state code and the timestamp to load.
// A notify stores the code with the current timestamp when it differs from
// the previous code. A read produces 16 results on m_*, newest entry first,
// one per cycle while m_tready is high, with m_tlast on the oldest one.
// Notify, tick and set requests are handled in the back end's idle state,
// so they sustain one request per cycle while no read holds the back end;
// a read holds it while the idle state starts the walk and the read state
// steps the results through the single output register.
// A read passes the front-end command register and the queue before its walk.
// A two-entry command queue sits between the decoding front end and the
// back end; requests are accepted during a stalled readout until both fill.
// When the receiver holds m_tready low the readout pauses on the current
// result and resumes without loss. Reset clears the ring to the off code,
// zeroes the timestamp and the write pointer. A write on cfg_we loads a new
// off code and clears the ring the same way, keeping the timestamp.
`default_nettype none
module state_change_history_log_unit (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_we,
	input  wire  [schl_pkg::CODE_W-1:0]   cfg_wdata,  // off_state_code
	input  wire                          s_tvalid,
	output logic                         s_tready,
	input  wire  [schl_pkg::S_DATA_W-1:0] s_tdata,   // state_code, time_value
	input  wire  [1:0]                   s_tuser,   // mode
	output logic                         m_tvalid,
	input  wire                          m_tready,
	output logic [schl_pkg::M_DATA_W-1:0] m_tdata,  // entry_state, entry_time, entry_age
	output logic                         m_tlast    // last_entry
);
	import schl_pkg::*;

	logic             push;
	logic             push_ready;
	cmd_t             push_cmd;
	logic             pop_valid;
	logic             pop;
	cmd_t             pop_cmd;
	logic [AGE_W-1:0] out_age;

	schl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.push      (push),
		.push_ready(push_ready),
		.push_cmd  (push_cmd)
	);

	schl_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_ready(push_ready),
		.push_cmd  (push_cmd),
		.pop_valid (pop_valid),
		.pop       (pop),
		.pop_cmd   (pop_cmd)
	);

	schl_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.pop_valid(pop_valid),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	assign out_age = m_tdata[CODE_W + TIME_W +: AGE_W];

	// the oldest entry always carries the highest age
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> (out_age == AGE_W'(READ_CNT - 1)))
		else $error("last entry with wrong age");

	// a readout streams without gaps once a result is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
		else $error("gap inside readout");

	// ages count up by one within a readout
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=> (out_age == $past(out_age) + 1'b1))
		else $error("readout age out of sequence");

endmodule
`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for state_change_history_log_unit: random bursty requests,
// a stalling receiver and an in-bench history predictor checked against readouts.
// Depends on schl_pkg and the unit RTL only.
module tb;
	import schl_pkg::*;

	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 24;
	localparam int IDLE_LIMIT   = 3000;

	typedef struct {
		logic [CODE_W-1:0] state;
		logic [TIME_W-1:0] stamp;
		logic [AGE_W-1:0]  age;
		logic              last;
	} log_entry_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                cfg_we    = 1'b0;
	logic [CODE_W-1:0]   cfg_wdata = '0;
	logic                s_tvalid  = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata   = '0;
	logic [1:0]          s_tuser   = '0;
	logic                m_tvalid;
	logic                m_tready  = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;
	logic                m_tlast;

	// history predictor
	logic [CODE_W-1:0] ring_code [DEPTH];
	logic [TIME_W-1:0] ring_stamp[DEPTH];
	logic [CODE_W-1:0] off_code;
	logic [CODE_W-1:0] prev_code;
	int unsigned       wr_ptr;
	logic [TIME_W-1:0] stamp;

	cmd_t       req_q[$];
	log_entry_t readout_q[$];
	int         queued_cnt   = 0;
	int         accepted_cnt = 0;
	int         err_cnt      = 0;
	int         hold_ask     = 0;
	logic [CODE_W-1:0] last_notify;

	state_change_history_log_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void clear_ring();
		for (int i = 0; i < DEPTH; i++) begin
			ring_code[i]  = off_code;
			ring_stamp[i] = '0;
		end
		prev_code = off_code;
		wr_ptr    = 0;
	endfunction

	function automatic void log_request(cmd_t r);
		int unsigned pos;
		log_entry_t  e;
		case (r.op)
			OP_NOTIFY: begin
				if (r.code != prev_code) begin
					prev_code          = r.code;
					ring_code[wr_ptr]  = r.code;
					ring_stamp[wr_ptr] = stamp;
					wr_ptr             = (wr_ptr + 1 == DEPTH) ? 0 : wr_ptr + 1;
				end
			end
			OP_TICK: stamp = stamp + 1'b1;
			OP_SET:  stamp = r.tval;
			default: begin
				// walk back from the newest entry
				pos = wr_ptr;
				for (int k = 0; k < READ_CNT; k++) begin
					pos     = (pos == 0) ? DEPTH - 1 : pos - 1;
					e.state = ring_code[pos];
					e.stamp = ring_stamp[pos];
					e.age   = k[AGE_W-1:0];
					e.last  = (k + 1 == READ_CNT);
					readout_q.push_back(e);
				end
			end
		endcase
	endfunction

	function automatic void check_field(string name, longint unsigned want, longint unsigned got);
		if (want != got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			err_cnt++;
		end
	endfunction

	// sender: bursts of requests separated by random gaps
	int burst_left = 4;
	int gap_left   = 0;

	always @(posedge clk) begin
		cmd_t acc;
		cmd_t nxt;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				acc.op   = op_t'(s_tuser);
				acc.code = s_tdata[CODE_W-1:0];
				acc.tval = s_tdata[CODE_W +: TIME_W];
				log_request(acc);
				accepted_cnt++;
			end
			if (!(s_tvalid && !s_tready)) begin
				if (gap_left != 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (req_q.size() != 0) begin
					nxt = req_q.pop_front();
					s_tvalid <= 1'b1;
					s_tuser  <= nxt.op;
					s_tdata  <= {nxt.tval, nxt.code};
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 24);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: checks results and stalls on a pattern of its own
	int hold_seen = 0;
	int hold_left = 0;
	int pat_mode  = 0;
	int pat_left  = 0;
	int pat_phase = 0;

	always @(posedge clk) begin
		log_entry_t e;
		logic       rdy;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (readout_q.size() == 0) begin
					$error("unexpected result: state 0x%0h time 0x%0h",
						m_tdata[CODE_W-1:0], m_tdata[CODE_W +: TIME_W]);
					err_cnt++;
				end else begin
					e = readout_q.pop_front();
					check_field("entry_state", e.state, m_tdata[CODE_W-1:0]);
					check_field("entry_time", e.stamp, m_tdata[CODE_W +: TIME_W]);
					check_field("entry_age", e.age, m_tdata[CODE_W+TIME_W +: AGE_W]);
					check_field("last_entry", e.last, m_tlast);
				end
			end
			if (hold_ask != hold_seen) begin
				hold_seen = hold_ask;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				rdy = 1'b0;
			end else begin
				if (pat_left == 0) begin
					pat_mode = $urandom_range(0, 3);
					pat_left = $urandom_range(20, 120);
				end
				pat_left--;
				pat_phase++;
				case (pat_mode)
					0:       rdy = 1'b1;
					1:       rdy = ($urandom_range(0, 1) == 1);
					2:       rdy = ($urandom_range(0, 3) == 0);
					default: rdy = (pat_phase % 3 != 0);
				endcase
			end
			m_tready <= rdy;
		end
	end

	int idle_cycles = 0;

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic add_req(input op_t op, input logic [CODE_W-1:0] code,
		input logic [TIME_W-1:0] tval);
		cmd_t r;
		r.op   = op;
		r.code = code;
		r.tval = tval;
		req_q.push_back(r);
		queued_cnt++;
		if (op == OP_NOTIFY)
			last_notify = code;
	endtask

	task automatic queue_random(input int count, input int read_pct);
		int                r;
		logic [CODE_W-1:0] code;
		logic [TIME_W-1:0] tval;
		add_req(OP_READ, CODE_W'($urandom_range(0, 255)), $urandom);
		for (int i = 1; i < count; i++) begin
			r    = $urandom_range(0, 99);
			code = CODE_W'($urandom_range(0, 255));
			tval = $urandom;
			if (r < read_pct) begin
				add_req(OP_READ, code, tval);
			end else if (r < read_pct + 10) begin
				add_req(OP_TICK, code, tval);
			end else if (r < read_pct + 16) begin
				if ($urandom_range(0, 3) == 0)
					tval = 32'hFFFF_FFFF - $urandom_range(0, 2);
				add_req(OP_SET, code, tval);
			end else begin
				case ($urandom_range(0, 4))
					0:       code = last_notify;
					1:       code = off_code;
					default: ;
				endcase
				add_req(OP_NOTIFY, code, tval);
			end
		end
	endtask

	// hold until every request is taken and every readout has arrived
	task automatic settle();
		while (accepted_cnt != queued_cnt || readout_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_off_code(input logic [CODE_W-1:0] v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		off_code    = v;
		last_notify = v;
		clear_ring();
	endtask

	initial begin
		off_code    = '0;
		stamp       = '0;
		last_notify = '0;
		clear_ring();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: cleared ring, repeated and off codes, timestamp wrap, extremes
		add_req(OP_READ,   8'h00, $urandom);
		add_req(OP_NOTIFY, 8'h00, $urandom);
		add_req(OP_NOTIFY, 8'hFF, $urandom);
		add_req(OP_TICK,   8'hFF, 32'hFFFF_FFFF);
		add_req(OP_NOTIFY, 8'h00, 32'h0);
		add_req(OP_NOTIFY, 8'h00, $urandom);
		add_req(OP_SET,    8'h00, 32'hFFFF_FFFF);
		add_req(OP_NOTIFY, 8'h5A, $urandom);
		add_req(OP_TICK,   8'h00, $urandom);
		add_req(OP_NOTIFY, 8'hA5, $urandom);
		add_req(OP_READ,   8'hFF, 32'hFFFF_FFFF);
		add_req(OP_SET,    8'hFF, 32'h0000_0000);
		add_req(OP_NOTIFY, 8'h01, $urandom);
		add_req(OP_SET,    8'h00, 32'h8000_0001);
		add_req(OP_NOTIFY, 8'h80, $urandom);
		add_req(OP_TICK,   8'h00, $urandom);
		add_req(OP_TICK,   8'h00, $urandom);
		add_req(OP_NOTIFY, 8'h7F, $urandom);
		add_req(OP_NOTIFY, 8'h7F, $urandom);
		add_req(OP_NOTIFY, 8'hFE, $urandom);
		add_req(OP_READ,   8'h00, 32'h0);
		settle();

		write_off_code(8'hFF);
		queue_random(110, 12);
		settle();

		// long receiver hold while read-heavy traffic backs up the input
		write_off_code(8'h00);
		hold_ask <= hold_ask + 1;
		queue_random(110, 30);
		settle();

		write_off_code(CODE_W'($urandom_range(1, 254)));
		queue_random(120, 10);
		settle();

		write_off_code(CODE_W'($urandom_range(0, 255)));
		queue_random(100, 15);
		settle();

		if (err_cnt == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
